// ===== sv/tcw_pkg.sv =====
// Shared constants, codes, handshake structs and address helpers for the text console.
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);

    localparam int KIND_W = 2;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = 16;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'h0F;

    typedef logic [1:0] t_cur_op;
    localparam t_cur_op CUR_HOLD      = 2'd0;
    localparam t_cur_op CUR_COL_INC   = 2'd1;
    localparam t_cur_op CUR_NEXT_LINE = 2'd2;
    localparam t_cur_op CUR_HOME      = 2'd3;

    typedef struct packed {
        logic    accept;
        logic    put_write;
        t_cur_op cur_op;
        logic    rd_issue;
        logic    rd_capture;
        logic    sweep_start_all;
        logic    sweep_start_row;
        logic    sweep_step;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              newline;
        logic              col_last;
        logic              row_last;
        logic              read_ok;
        logic              sweep_last;
        logic              out_free;
    } t_dp_status;

    // logical screen row -> physical row of the circular row buffer
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                 input logic [ROW_W-1:0] top);
        logic [ROW_W:0] s;
        s = {1'b0, lrow} + {1'b0, top};
        if (s >= (ROW_W+1)'(ROWS)) begin
            s = s - (ROW_W+1)'(ROWS);
        end
        return s[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

// ===== sv/text_console_writer.sv =====
// Text console top level: 80x25 cell grid with cursor, put, read and clear operations.
// One item at a time. After reset the grid is filled with blanks (space, attribute 0x0F)
// by a pass over every cell, one cell per cycle, during which no item is taken; the
// attribute register may be written meanwhile. A read inside the grid uses a registered
// memory read; a read outside the grid or of kind 3 skips the memory. A put or newline
// that moves past the bottom row also blanks the new bottom row (rows are a circular
// buffer, so a scroll only rewrites one row); a clear blanks every cell. A finished
// result waits for the previous beat to be taken; the cell memory's single write port
// makes each sweep write one cell at a time. A result may wait in the output register
// while the next item is accepted. The attribute register is always ready.
module text_console_writer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [tcw_pkg::KIND_W-1:0]    i_kind,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]     i_read_row,
    input  logic [tcw_pkg::COL_W-1:0]     i_read_col,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tcw_pkg::CELL_W-1:0]    o_cell_data,
    output logic [tcw_pkg::ROW_W-1:0]     o_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]     o_cursor_col,
    output logic                          o_scrolled,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_cfg_data
);
    import tcw_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    tcw_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_cell_data  (o_cell_data),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_scrolled   (o_scrolled)
    );

endmodule

// ===== sv/tcw_dpath.sv =====
// Datapath: cell memory, cursor, row offset, fill sweep counters, item and result registers.
module tcw_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcw_pkg::t_dp_cmd              i_cmd,
    output tcw_pkg::t_dp_status           o_status,
    input  logic [tcw_pkg::KIND_W-1:0]    i_kind,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]     i_read_row,
    input  logic [tcw_pkg::COL_W-1:0]     i_read_col,
    input  logic                          i_cfg_valid,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_cfg_data,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [tcw_pkg::CELL_W-1:0]    o_cell_data,
    output logic [tcw_pkg::ROW_W-1:0]     o_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]     o_cursor_col,
    output logic                          o_scrolled
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [CELLS];

    logic [KIND_W-1:0] r_kind;
    logic [CHAR_W-1:0] r_code;
    logic [ROW_W-1:0]  r_rrow;
    logic [COL_W-1:0]  r_rcol;
    logic [CHAR_W-1:0] r_attr;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_top;
    logic [ROW_W-1:0]  r_sw_row;
    logic [COL_W-1:0]  r_sw_col;
    logic              r_sw_all;
    logic              r_sw_init;
    logic [CELL_W-1:0] r_rdata;
    logic [CELL_W-1:0] r_data;
    logic              r_scrolled;
    logic              r_ov;
    logic [CELL_W-1:0] r_o_data;
    logic [ROW_W-1:0]  r_o_row;
    logic [COL_W-1:0]  r_o_col;
    logic              r_o_scr;

    logic [ADDR_W-1:0] put_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] sw_addr;
    logic [CELL_W-1:0] fill;
    logic              sweep_last;
    logic              row_last;

    assign put_addr   = cell_addr(phys_row(r_row, r_top), r_col);
    assign rd_addr    = cell_addr(phys_row(r_rrow, r_top), r_rcol);
    assign sw_addr    = cell_addr(r_sw_row, r_sw_col);
    assign fill       = r_sw_init ? {RESET_ATTR, SPACE_CODE} : {r_attr, SPACE_CODE};
    assign sweep_last = (r_sw_col == LAST_COL) && (!r_sw_all || (r_sw_row == LAST_ROW));
    assign row_last   = (r_row == LAST_ROW);

    always_comb begin
        o_status            = '0;
        o_status.kind       = r_kind;
        o_status.newline    = (r_code == NEWLINE_CODE);
        o_status.col_last   = (r_col == LAST_COL);
        o_status.row_last   = row_last;
        o_status.read_ok    = (r_rrow <= LAST_ROW) && (r_rcol <= LAST_COL);
        o_status.sweep_last = sweep_last;
        o_status.out_free   = !r_ov || !i_stall;
    end

    // cursor update
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        unique case (i_cmd.cur_op)
            CUR_HOLD: begin
            end
            CUR_COL_INC: begin
                n_col = r_col + 1'b1;
            end
            CUR_NEXT_LINE: begin
                n_col = '0;
                n_row = row_last ? r_row : r_row + 1'b1;
            end
            CUR_HOME: begin
                n_col = '0;
                n_row = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put_write) begin
            mem[put_addr] <= {r_attr, r_code};
        end else if (i_cmd.sweep_step) begin
            mem[sw_addr] <= fill;
        end
        if (i_cmd.rd_issue) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_kind;
            r_code <= i_char_code;
            r_rrow <= i_read_row;
            r_rcol <= i_read_col;
        end
        if (i_cmd.out_load) begin
            r_o_data <= r_data;
            r_o_row  <= r_row;
            r_o_col  <= r_col;
            r_o_scr  <= r_scrolled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr     <= RESET_ATTR;
            r_row      <= '0;
            r_col      <= '0;
            r_top      <= '0;
            r_sw_row   <= '0;
            r_sw_col   <= '0;
            r_sw_all   <= 1'b1;
            r_sw_init  <= 1'b1;
            r_data     <= '0;
            r_scrolled <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_attr <= i_cfg_data;
            end
            r_row <= n_row;
            r_col <= n_col;

            if (i_cmd.accept) begin
                r_data     <= '0;
                r_scrolled <= 1'b0;
            end else if (i_cmd.rd_capture) begin
                r_data <= r_rdata;
            end else if (i_cmd.cur_op == CUR_NEXT_LINE && row_last) begin
                r_scrolled <= 1'b1;
            end

            if (i_cmd.sweep_start_all) begin
                r_sw_row  <= '0;
                r_sw_col  <= '0;
                r_sw_all  <= 1'b1;
                r_sw_init <= 1'b0;
                r_top     <= '0;
            end else if (i_cmd.sweep_start_row) begin
                // new bottom row lives where the old top row was
                r_sw_row  <= r_top;
                r_sw_col  <= '0;
                r_sw_all  <= 1'b0;
                r_sw_init <= 1'b0;
            end else if (i_cmd.sweep_step) begin
                if (r_sw_col == LAST_COL) begin
                    r_sw_col <= '0;
                    r_sw_row <= r_sw_row + 1'b1;
                end else begin
                    r_sw_col <= r_sw_col + 1'b1;
                end
                if (sweep_last && !r_sw_all) begin
                    r_top <= (r_top == LAST_ROW) ? '0 : r_top + 1'b1;
                end
            end

            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid      = r_ov;
    assign o_cell_data  = r_o_data;
    assign o_cursor_row = r_o_row;
    assign o_cursor_col = r_o_col;
    assign o_scrolled   = r_o_scr;

    cursor_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= LAST_ROW) && (r_col <= LAST_COL))
        else $error("cursor left the grid");

    top_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= LAST_ROW)
        else $error("row offset out of range");

    no_write_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.put_write && i_cmd.sweep_step))
        else $error("put and sweep write in the same cycle");

endmodule

// ===== sv/tcw_ctrl.sv =====
// Controller: sequences accept, execute, read, fill sweeps and result hand-off.
module tcw_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  tcw_pkg::t_dp_status   i_status,
    output tcw_pkg::t_dp_cmd      o_cmd
);
    import tcw_pkg::*;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_SWEEP  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] r_state, n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                if (i_status.kind == KIND_PUT) begin
                    if (i_status.newline || i_status.col_last) begin
                        o_cmd.cur_op = CUR_NEXT_LINE;
                        if (i_status.row_last) begin
                            o_cmd.sweep_start_row = 1'b1;
                            n_state               = S_SWEEP;
                        end
                    end else begin
                        o_cmd.cur_op = CUR_COL_INC;
                    end
                    o_cmd.put_write = !i_status.newline;
                end else if (i_status.kind == KIND_READ) begin
                    if (i_status.read_ok) begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = S_RDWAIT;
                    end
                end else if (i_status.kind == KIND_CLEAR) begin
                    o_cmd.cur_op          = CUR_HOME;
                    o_cmd.sweep_start_all = 1'b1;
                    n_state               = S_SWEEP;
                end
            end
            S_RDWAIT: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = S_DONE;
            end
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("result loaded over an untaken beat");

    accept_goes_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_EXEC))
        else $error("accepted item not executed");

    sweep_only_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sweep_step |-> (r_state == S_SWEEP || r_state == S_INIT))
        else $error("sweep step outside a sweep");

    read_then_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_issue |=> o_cmd.rd_capture)
        else $error("issued read not captured");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the text console: directed table, then random phases with attribute changes.
`timescale 1ns / 1ps

module testbench;
    import tcw_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned LIMIT_CYCLES  = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned PHASE_ITEMS   = 110;
    localparam int unsigned PHASES        = 5;
    localparam int unsigned DIRECTED_N    = 20;

    typedef struct packed {
        logic [CELL_W-1:0] data;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              scrolled;
    } t_console_view;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] code;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              typed;
        t_console_view     view;
    } t_stim_row;

    localparam t_console_view VIEW_ZERO = '0;
    localparam logic [CELL_W-1:0] BLANK_RESET = {RESET_ATTR, SPACE_CODE};

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic [KIND_W-1:0]   i_kind      = '0;
    logic [CHAR_W-1:0]   i_char_code = '0;
    logic [ROW_W-1:0]    i_read_row  = '0;
    logic [COL_W-1:0]    i_read_col  = '0;
    logic                i_stall     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [CHAR_W-1:0]   i_cfg_data  = '0;
    logic                o_stall;
    logic                o_valid;
    logic [CELL_W-1:0]   o_cell_data;
    logic [ROW_W-1:0]    o_cursor_row;
    logic [COL_W-1:0]    o_cursor_col;
    logic                o_scrolled;
    logic                o_cfg_ready;

    text_console_writer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cell_data  (o_cell_data),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_scrolled   (o_scrolled),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // shadow copy of the screen, cursor and attribute
    logic [CELL_W-1:0] shadow_cells [CELLS];
    logic [ROW_W-1:0]  shadow_row;
    logic [COL_W-1:0]  shadow_col;
    logic [CHAR_W-1:0] shadow_attr;

    t_console_view expected_views [$];
    int unsigned   fail_count   = 0;
    int unsigned   cycle_count  = 0;
    int unsigned   items_sent   = 0;
    int unsigned   read_count   = 0;
    int unsigned   clear_count  = 0;
    int unsigned   scroll_count = 0;
    int unsigned   attr_writes  = 0;

    // directed items: kind, code, row, col, typed, {data, cursor row, cursor col, scrolled}
    t_stim_row directed_rows [DIRECTED_N] = '{
        {KIND_READ,   8'h00, 5'd0,  7'd0,   1'b1, BLANK_RESET, 5'd0, 7'd0, 1'b0},
        {KIND_READ,   8'hFF, 5'd24, 7'd79,  1'b1, BLANK_RESET, 5'd0, 7'd0, 1'b0},
        {KIND_READ,   8'h00, 5'd25, 7'd0,   1'b1, VIEW_ZERO},
        {KIND_READ,   8'h00, 5'd31, 7'd127, 1'b1, VIEW_ZERO},
        {KIND_READ,   8'h00, 5'd0,  7'd80,  1'b1, VIEW_ZERO},
        {KIND_UNUSED, 8'hFF, 5'd31, 7'd127, 1'b1, VIEW_ZERO},
        {KIND_PUT,    8'h41, 5'd0,  7'd0,   1'b1, 16'h0000, 5'd0, 7'd1, 1'b0},
        {KIND_PUT,    8'h00, 5'd31, 7'd127, 1'b0, VIEW_ZERO},
        {KIND_PUT,    8'hFF, 5'd0,  7'd0,   1'b0, VIEW_ZERO},
        {KIND_READ,   8'h00, 5'd0,  7'd0,   1'b0, VIEW_ZERO},
        {KIND_READ,   8'h00, 5'd0,  7'd2,   1'b0, VIEW_ZERO},
        {KIND_PUT,    NEWLINE_CODE, 5'd0, 7'd0, 1'b0, VIEW_ZERO},
        {KIND_READ,   8'h00, 5'd1,  7'd0,   1'b0, VIEW_ZERO},
        {KIND_PUT,    NEWLINE_CODE, 5'd0, 7'd0, 1'b0, VIEW_ZERO},
        {KIND_PUT,    8'h7F, 5'd0,  7'd0,   1'b0, VIEW_ZERO},
        {KIND_CLEAR,  8'h0A, 5'd31, 7'd127, 1'b1, VIEW_ZERO},
        {KIND_READ,   8'h00, 5'd0,  7'd0,   1'b1, BLANK_RESET, 5'd0, 7'd0, 1'b0},
        {KIND_READ,   8'h00, 5'd2,  7'd0,   1'b1, BLANK_RESET, 5'd0, 7'd0, 1'b0},
        {KIND_UNUSED, 8'h00, 5'd0,  7'd0,   1'b1, VIEW_ZERO},
        {KIND_PUT,    8'h80, 5'd0,  7'd0,   1'b0, VIEW_ZERO}
    };

    function automatic int unsigned idle_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
    endfunction

    function automatic void shadow_reset();
        foreach (shadow_cells[n]) shadow_cells[n] = BLANK_RESET;
        shadow_row  = '0;
        shadow_col  = '0;
        shadow_attr = RESET_ATTR;
    endfunction

    // cursor to start of next line; scrolls when already on the bottom row
    function automatic logic shadow_next_line();
        shadow_col = '0;
        if (shadow_row == LAST_ROW) begin
            for (int n = 0; n < CELLS - COLUMNS; n++) shadow_cells[n] = shadow_cells[n + COLUMNS];
            for (int n = CELLS - COLUMNS; n < CELLS; n++) shadow_cells[n] = {shadow_attr, SPACE_CODE};
            return 1'b1;
        end
        shadow_row = shadow_row + 1'b1;
        return 1'b0;
    endfunction

    function automatic t_console_view console_step(input logic [KIND_W-1:0] kind,
                                                   input logic [CHAR_W-1:0] code,
                                                   input logic [ROW_W-1:0]  row,
                                                   input logic [COL_W-1:0]  col);
        t_console_view v;
        v = '0;
        case (kind)
            KIND_PUT: begin
                if (code == NEWLINE_CODE) begin
                    v.scrolled = shadow_next_line();
                end else begin
                    shadow_cells[int'(shadow_row) * COLUMNS + int'(shadow_col)] = {shadow_attr, code};
                    if (shadow_col == LAST_COL) begin
                        v.scrolled = shadow_next_line();
                    end else begin
                        shadow_col = shadow_col + 1'b1;
                    end
                end
            end
            KIND_READ: begin
                if (int'(row) < ROWS && int'(col) < COLUMNS) begin
                    v.data = shadow_cells[int'(row) * COLUMNS + int'(col)];
                end
            end
            KIND_CLEAR: begin
                foreach (shadow_cells[n]) shadow_cells[n] = {shadow_attr, SPACE_CODE};
                shadow_row = '0;
                shadow_col = '0;
            end
            default: ;
        endcase
        v.row = shadow_row;
        v.col = shadow_col;
        return v;
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < 10) $display("%s", msg);
        fail_count++;
    endtask

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] code,
                             input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                             input logic typed, input t_console_view typed_view,
                             input logic paced);
        t_console_view v;
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_char_code <= code;
        i_read_row  <= row;
        i_read_col  <= col;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        v = console_step(kind, code, row, col);
        expected_views.push_back(typed ? typed_view : v);
        if (v.scrolled) scroll_count++;
        items_sent++;
        if (kind == KIND_READ) read_count++;
        if (kind == KIND_CLEAR) clear_count++;
        if (paced && $urandom_range(0, 99) < 45) begin
            i_valid <= 1'b0;
            repeat (idle_len()) @(posedge i_clk);
        end
    endtask

    // every item gives a result, so an empty queue means the block is idle
    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_views.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_attribute(input logic [CHAR_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        shadow_attr = value;
        attr_writes++;
    endtask

    task automatic random_burst(inout int unsigned clears_left);
        int unsigned pick;
        int unsigned len;
        logic        paced;
        logic [CHAR_W-1:0] code;
        pick  = $urandom_range(0, 99);
        paced = ($urandom_range(0, 3) != 0);
        if (pick < 40) begin
            len = $urandom_range(1, 60);
            repeat (len) begin
                code = ($urandom_range(0, 11) == 0) ? NEWLINE_CODE : CHAR_W'($urandom_range(0, 255));
                send_item(KIND_PUT, code, ROW_W'($urandom), COL_W'($urandom), 1'b0, VIEW_ZERO, paced);
            end
        end else if (pick < 60) begin
            len = $urandom_range(1, 30);
            repeat (len) send_item(KIND_PUT, NEWLINE_CODE, ROW_W'($urandom), COL_W'($urandom),
                                   1'b0, VIEW_ZERO, paced);
        end else if (pick < 85) begin
            len = $urandom_range(1, 6);
            repeat (len) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_item(KIND_READ, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom),
                              1'b0, VIEW_ZERO, paced);
                end else begin
                    send_item(KIND_READ, CHAR_W'($urandom), ROW_W'($urandom_range(0, ROWS - 1)),
                              COL_W'($urandom_range(0, COLUMNS - 1)), 1'b0, VIEW_ZERO, paced);
                end
            end
        end else if (pick < 95 || clears_left == 0) begin
            len = $urandom_range(1, 3);
            repeat (len) send_item(KIND_UNUSED, CHAR_W'($urandom), ROW_W'($urandom),
                                   COL_W'($urandom), 1'b0, VIEW_ZERO, paced);
        end else begin
            clears_left--;
            send_item(KIND_CLEAR, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom),
                      1'b0, VIEW_ZERO, paced);
        end
    endtask

    initial begin : stimulus
        int unsigned clears_left;
        int unsigned target;
        logic [CHAR_W-1:0] attr_plan [PHASES];
        clears_left = 10;
        attr_plan = '{8'h00, 8'hFF, CHAR_W'($urandom), 8'h5A, CHAR_W'($urandom)};
        shadow_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            send_item(directed_rows[n].kind, directed_rows[n].code, directed_rows[n].row,
                      directed_rows[n].col, directed_rows[n].typed, directed_rows[n].view, 1'b1);
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            write_attribute(attr_plan[p]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) random_burst(clears_left);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_views.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", expected_views.size()));
        end
        $display("summary: %0d items, %0d reads, %0d clears, %0d scrolls, %0d attribute writes",
                 items_sent, read_count, clear_count, scroll_count, attr_writes);
        if (fail_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("summary: %0d failures", fail_count);
            $display("testbench: done, errors");
        end
        $finish;
    end

    // receiver backpressure: mostly short stalls, some long, with calm stretches
    int unsigned rx_hold = 0;
    int unsigned rx_calm = 0;
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            i_stall <= 1'b1;
            rx_hold <= rx_hold - 1;
        end else begin
            i_stall <= 1'b0;
            if (rx_calm != 0) begin
                rx_calm <= rx_calm - 1;
            end else if ($urandom_range(0, 99) < 2) begin
                rx_calm <= $urandom_range(50, 300);
            end else if ($urandom_range(0, 99) < 30) begin
                rx_hold <= idle_len();
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_console_view got;
        t_console_view want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            got = {o_cell_data, o_cursor_row, o_cursor_col, o_scrolled};
            if (expected_views.size() == 0) begin
                note_failure($sformatf("unexpected beat: data=%h row=%0d col=%0d scrolled=%0b",
                                       got.data, got.row, got.col, got.scrolled));
            end else begin
                want = expected_views.pop_front();
                if (got !== want) begin
                    note_failure($sformatf({"mismatch: expected data=%h row=%0d col=%0d ",
                                            "scrolled=%0b, got data=%h row=%0d col=%0d scrolled=%0b"},
                                           want.data, want.row, want.col, want.scrolled,
                                           got.data, got.row, got.col, got.scrolled));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_views.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
sv/tcw_pkg.sv
sv/tcw_dpath.sv
sv/tcw_ctrl.sv
sv/text_console_writer.sv
tb/testbench.sv
